// File: src/ufs_pkg.sv
// Shared types for the duplicate-rejecting queue and its cell row.
`default_nettype none
package ufs_pkg;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_MIDDLE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_COMPARE = 2'd1,
      S_UPDATE  = 2'd2
   } state_type;

   // Broadcast to every cell of the row.
   typedef struct packed {
      logic               shift;
      logic               insert;
      logic signed [31:0] key;
   } cell_ctl_type;

endpackage
`default_nettype wire

// File: src/ufs_cell.sv
// One queue cell: holds one entry, compares it with the key and shifts towards the head.
`default_nettype none
module ufs_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  ufs_pkg::cell_ctl_type ctl,
   input  logic                  lower_valid,
   input  logic                  upper_valid,
   input  logic signed [31:0]    upper_value,
   output logic                  valid,
   output logic signed [31:0]    value,
   output logic                  hit
);
   import ufs_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic signed [31:0] value_ff;
   logic signed [31:0] value_in;
   logic               hit_ff;
   logic               hit_in;

   always_comb begin
      // The tail slot is the first empty cell: cell zero, or an empty cell above an occupied one.
      priority if (ctl.shift) begin
         valid_in = upper_valid;
         value_in = upper_value;
      end else if (ctl.insert && !valid_ff && lower_valid) begin
         valid_in = 1'b1;
         value_in = ctl.key;
      end else begin
         valid_in = valid_ff;
         value_in = value_ff;
      end
      hit_in = valid_ff && (value_ff == ctl.key);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      hit_ff   <= hit_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign hit   = hit_ff;

endmodule
`default_nettype wire

// File: src/unique_fifo_with_search.sv
// The response is registered: a command passes the compare and update states before
// its response is presented. The block takes no new command until that response is
// transferred; the input reopens only in the cycle after the response transfer.
// Reset clears the cell valid bits, the entry count and the control state;
// stored entry values are not cleared.
`default_nettype none
module unique_fifo_with_search #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] data_value
   input  logic [1:0]  req_tuser,  // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] result_value, [36:32] occupancy, [39:37] zero
   output logic [2:0]  rsp_tuser   // [2:0] status
);
   import ufs_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   state_type          state_ff;
   state_type          state_in;
   op_type             op_ff;
   op_type             op_in;
   logic signed [31:0] key_ff;
   logic signed [31:0] key_in;
   logic [CW-1:0]      count_ff;
   logic [CW-1:0]      count_in;
   logic signed [31:0] mid_ff;
   logic signed [31:0] mid_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   status_type         rsp_status_in;
   logic signed [31:0] rsp_result_ff;
   logic signed [31:0] rsp_result_in;
   logic [4:0]         rsp_occ_ff;
   logic [4:0]         rsp_occ_in;

   cell_ctl_type       ctl;
   logic [IW-1:0]      mid_idx;
   logic               any_hit;
   logic               is_empty;
   logic               is_full;

   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [QUEUE_DEPTH-1:0] cell_hit;
   logic signed [31:0]     cell_value [QUEUE_DEPTH];

   // Cell zero is the head; removal shifts every entry one cell down.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic               lower_valid;
      logic               upper_valid;
      logic signed [31:0] upper_value;

      if (i == 0) begin : g_head
         assign lower_valid = 1'b1;
      end else begin : g_body
         assign lower_valid = cell_valid[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign upper_valid = 1'b0;
         assign upper_value = '0;
      end else begin : g_inner
         assign upper_valid = cell_valid[i+1];
         assign upper_value = cell_value[i+1];
      end

      ufs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .lower_valid (lower_valid),
         .upper_valid (upper_valid),
         .upper_value (upper_value),
         .valid       (cell_valid[i]),
         .value       (cell_value[i]),
         .hit         (cell_hit[i])
      );
   end

   assign mid_idx  = IW'(count_ff >> 1);
   assign any_hit  = |cell_hit;
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CW'(QUEUE_DEPTH));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      mid_in        = mid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_result_in = rsp_result_ff;
      rsp_occ_in    = rsp_occ_ff;
      req_tready    = 1'b0;
      ctl.shift     = 1'b0;
      ctl.insert    = 1'b0;
      ctl.key       = key_ff;

      unique case (state_ff)
         S_IDLE: begin
            req_tready = !rsp_valid_ff;
            if (req_tvalid && !rsp_valid_ff) begin
               op_in    = op_type'(req_tuser);
               key_in   = req_tdata;
               state_in = S_COMPARE;
            end
         end
         S_COMPARE: begin
            // The cells register their match bits during this cycle.
            mid_in   = cell_value[mid_idx];
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            rsp_result_in = '0;
            rsp_status_in = ST_OK;
            unique case (op_ff)
               OP_INSERT: begin
                  if (any_hit) begin
                     rsp_status_in = ST_DUPLICATE;
                  end else if (is_full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     ctl.insert = 1'b1;
                     count_in   = CW'(count_ff + 1'b1);
                  end
               end
               OP_REMOVE: begin
                  if (is_empty) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     ctl.shift = 1'b1;
                     count_in  = CW'(count_ff - 1'b1);
                  end
               end
               OP_SEARCH: begin
                  rsp_status_in = any_hit ? ST_OK : ST_NOT_FOUND;
               end
               OP_MIDDLE: begin
                  if (is_empty) begin
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     rsp_result_in = mid_ff;
                  end
               end
               default: begin
                  rsp_status_in = ST_OK;
               end
            endcase
            rsp_occ_in   = 5'(count_in);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      mid_ff        <= mid_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_result_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire
